/* hw/rtl/mbce_pkg.sv */
// Shared types and constants for the monochrome bitmap color expansion blit.
package mbce_pkg;

  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned ORG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned BPL_W     = 11;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = 1;
  localparam int unsigned Q_CNT_W   = 2;

  localparam logic [DIM_W-1:0] CNT_MAX     = 13'h1FFF;
  localparam logic [DIM_W-1:0] MAX_DIM_VAL = 13'(MAX_DIM);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_WIDTH   = 3'd0,
    REG_DEST_HEIGHT  = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_ORIGIN_Y     = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5,
    REG_SKIP_ROWS    = 3'd6,
    REG_FG_COLOR     = 3'd7
  } cfg_reg_t;

  // One byte's worth of drawing work: lanes to emit and where they land.
  typedef struct packed {
    logic [7:0]         mask;
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
  } job_t;

  function automatic logic [2:0] lowest_bit(input logic [7:0] m);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* hw/rtl/mbce_front.sv */
// Front end: configuration registers, row/column counters and byte classification.
module mbce_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbce_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_bitmap_byte,
  input  logic                           in_first_byte,
  input  logic                           q_full,
  output logic                           q_push,
  output mbce_pkg::job_t                 q_job
);
  import mbce_pkg::*;

  logic [DIM_W-1:0]   dest_width_r, dest_height_r, image_width_r, image_height_r;
  logic [DIM_W-1:0]   skip_rows_r;
  logic [ORG_W-1:0]   origin_x_r, origin_y_r;
  logic [COLOR_W-1:0] fg_color_r;
  logic [DIM_W-1:0]   col_r, col_nxt, row_r, row_nxt;

  logic               accept;
  logic [DIM_W-1:0]   col_eff, row_eff;
  logic [DIM_W:0]     width_plus;
  logic [BPL_W-1:0]   bpl;
  logic               bpl_zero;
  logic [DIM_W-1:0]   dw, dh;
  logic [ORG_W:0]     right_edge;
  logic               fits;
  logic [17:0]        drow;
  logic               row_ok;
  logic [15:0]        colpx;
  logic [16:0]        rem;
  logic [7:0]         lanes;
  logic [7:0]         mask;
  logic [DIM_W:0]     col_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_width_r   <= '0;
      dest_height_r  <= '0;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      image_width_r  <= '0;
      image_height_r <= '0;
      skip_rows_r    <= '0;
      fg_color_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEST_WIDTH:   dest_width_r   <= cfg_data[DIM_W-1:0];
        REG_DEST_HEIGHT:  dest_height_r  <= cfg_data[DIM_W-1:0];
        REG_ORIGIN_X:     origin_x_r     <= cfg_data[ORG_W-1:0];
        REG_ORIGIN_Y:     origin_y_r     <= cfg_data[ORG_W-1:0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[DIM_W-1:0];
        REG_SKIP_ROWS:    skip_rows_r    <= cfg_data[DIM_W-1:0];
        REG_FG_COLOR:     fg_color_r     <= cfg_data[COLOR_W-1:0];
        default:          fg_color_r     <= fg_color_r;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign col_eff    = in_first_byte ? '0 : col_r;
  assign row_eff    = in_first_byte ? '0 : row_r;
  assign width_plus = {1'b0, image_width_r} + (DIM_W+1)'(7);
  assign bpl        = width_plus[DIM_W:3];
  assign bpl_zero   = (image_width_r == '0);

  assign dw = (dest_width_r  > MAX_DIM_VAL) ? MAX_DIM_VAL : dest_width_r;
  assign dh = (dest_height_r > MAX_DIM_VAL) ? MAX_DIM_VAL : dest_height_r;

  assign right_edge = {2'b00, origin_x_r[ORG_W-2:0]} + (ORG_W+1)'(image_width_r);
  assign fits       = !origin_x_r[ORG_W-1] && (right_edge <= (ORG_W+1)'(dw));

  assign drow   = {{2{origin_y_r[ORG_W-1]}}, origin_y_r} + 18'(row_eff) - 18'(skip_rows_r);
  assign row_ok = fits && (row_eff >= skip_rows_r) && (row_eff < image_height_r) &&
                  !drow[17] && (drow[16:0] < 17'(dh));

  assign colpx = {col_eff, 3'b000};
  assign rem   = 17'(image_width_r) - 17'(colpx);

  always_comb begin
    if (rem[16] || rem == '0) begin
      lanes = 8'h00;
    end else if (rem >= 17'd8) begin
      lanes = 8'hFF;
    end else begin
      lanes = (8'h01 << rem[2:0]) - 8'h01;
    end
  end

  assign mask = in_bitmap_byte & lanes & {8{row_ok}};

  assign q_job.mask   = mask;
  assign q_job.base_x = origin_x_r[COORD_W-1:0] + colpx[COORD_W-1:0];
  assign q_job.y      = drow[COORD_W-1:0];
  assign q_job.color  = fg_color_r;
  assign q_push       = accept && !bpl_zero && (mask != 8'h00);

  assign col_inc = {1'b0, col_eff} + (DIM_W+1)'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      col_nxt = col_eff;
      row_nxt = row_eff;
      if (!bpl_zero) begin
        if (col_inc >= (DIM_W+1)'(bpl)) begin
          col_nxt = '0;
          row_nxt = (row_eff == CNT_MAX) ? row_eff : row_eff + DIM_W'(1);
        end else begin
          col_nxt = col_inc[DIM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

`ifndef SYNTH
  a_push_has_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_valid && !q_full))
    else $error("job pushed without an accepted byte");
  a_push_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (row_ok && fits))
    else $error("job pushed for a row that is not drawn");
`endif

endmodule

/* hw/rtl/mbce_queue.sv */
// Short job queue between the front end and the pixel expander.
module mbce_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbce_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mbce_pkg::job_t head_job
);
  import mbce_pkg::*;

  job_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entries[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

/* hw/rtl/mbce_back.sv */
// Back end: expands one job into pixel writes, one per cycle while out_ready is high.
module mbce_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  mbce_pkg::job_t               q_job,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mbce_pkg::COORD_W-1:0] out_pixel_x,
  output logic [mbce_pkg::COORD_W-1:0] out_pixel_y,
  output logic [mbce_pkg::COLOR_W-1:0] out_pixel_color,
  output logic                         out_last_of_byte
);
  import mbce_pkg::*;

  job_t       cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic       take, load;
  logic [7:0] rest;
  logic [2:0] idx;

  assign idx  = lowest_bit(cur_r.mask);
  assign rest = cur_r.mask & (cur_r.mask - 8'h01);
  assign take = out_valid && out_ready;
  assign load = !cur_valid_r || (take && rest == 8'h00);
  assign q_pop = load && q_valid;

  assign out_valid        = cur_valid_r;
  assign out_pixel_x      = cur_r.base_x + COORD_W'(idx);
  assign out_pixel_y      = cur_r.y;
  assign out_pixel_color  = cur_r.color;
  assign out_last_of_byte = (rest == 8'h00);

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    if (load) begin
      cur_valid_nxt = q_valid;
      cur_nxt       = q_job;
    end else if (take) begin
      cur_nxt.mask = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

`ifndef SYNTH
  a_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.mask != 8'h00))
    else $error("active job with no pixels left");
  a_mask_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_last_of_byte) |=> (cur_valid_r && $countones(cur_r.mask) ==
                                    $countones($past(cur_r.mask)) - 1))
    else $error("pixel mask did not drop exactly one lane");
`endif

endmodule

/* hw/rtl/mono_bitmap_color_expand_blit.sv */
// Top level of the monochrome bitmap color expansion blit.
// Usage:
//   The input channel (in_valid/in_ready) takes one bitmap byte per transaction,
//   bit 0 the leftmost pixel, rows padded to whole bytes. in_first_byte marks
//   row 0, byte 0 of a new image and clears the row and column counters.
//   The output channel (out_valid/out_ready) carries one pixel write per
//   transaction: x, y, color and a flag on the last write caused by a byte.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data; the
//   user must do so only while no byte is in flight, which the block does not
//   enforce; they take effect on the next byte. With the expander free, a byte's
//   job goes into the queue and then into the expander's current-job register,
//   where out_valid rises. Throughput: the pixel expander emits one write per
//   cycle while out_ready is high, so a byte yields one write per drawn bit (up
//   to 8); bytes that draw nothing never reach the queue. A two-entry job queue
//   lets the front end keep taking bytes while the expander works.
//   Reset clears the registers, the counters and the queue.
//   When the receiver stalls, the current pixel holds, the queue fills and
//   then in_ready drops.
module mono_bitmap_color_expand_blit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbce_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_bitmap_byte,
  input  logic                           in_first_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mbce_pkg::COORD_W-1:0]   out_pixel_x,
  output logic [mbce_pkg::COORD_W-1:0]   out_pixel_y,
  output logic [mbce_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic                           out_last_of_byte
);
  import mbce_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, head_job;

  mbce_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_bitmap_byte (in_bitmap_byte),
    .in_first_byte  (in_first_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  mbce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  mbce_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_job            (head_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_color  (out_pixel_color),
    .out_last_of_byte (out_last_of_byte)
  );

endmodule
